/* rtl/ctfp_pkg.sv */
// Package for the point-to-circle tangent pipeline: widths, status codes, tdata packing.
// Depends on nothing; every rtl file imports it.
package ctfp_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_TWO       = 2'd0,
		ST_ON_CIRCLE = 2'd1,
		ST_COINCIDE  = 2'd2,
		ST_INSIDE    = 2'd3
	} status_t;

	localparam int OUT_W    = 32;
	localparam int TOL_W    = 16;
	localparam int ODATA_W  = 200;  // 6 x 32 + 2 status bits, padded to bytes
	localparam int UNIT_SH  = 30;   // Q2.30 fraction bits

	// One result word, highest field first; normal1_x sits in the low bits.
	typedef struct packed {
		logic [5:0]          pad;
		status_t             status;
		logic signed [31:0]  offset2;
		logic signed [31:0]  normal2_y;
		logic signed [31:0]  normal2_x;
		logic signed [31:0]  offset1;
		logic signed [31:0]  normal1_y;
		logic signed [31:0]  normal1_x;
	} result_t;

endpackage

/* rtl/circle_tangents_from_point.sv */
// Top level of the point-to-circle tangent pipeline.
// Depends on ctfp_pkg, ctfp_isqrt and ctfp_divq.
//
//  channel  | dir | fields (low bit first)
//  s_axis   | in  | centre_x, centre_y, point_x, point_y, radius
//  m_axis   | out | normal1_x, normal1_y, offset1, normal2_x, normal2_y, offset2, status
//  cfg      | in  | relative_tolerance
//
// One word enters per cycle unless the output stalls. The path for COORD_WIDTH 32: three
// front stages, the square-root pipeline (one stage per root bit, 35), two product
// stages, the divider (one stage per quotient bit, 32), the offset stage and the output.
// Reset clears all valid bits; the whole pipeline advances only when the
// output register is free or being taken, so a stall loses nothing.
module circle_tangents_from_point #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// centre_x, centre_y, point_x, point_y, radius, zero pad
	input  logic [((5*COORD_WIDTH+6)/8)*8-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// normal1_x, normal1_y, offset1, normal2_x, normal2_y, offset2, status
	output logic [ctfp_pkg::ODATA_W-1:0] m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [ctfp_pkg::TOL_W-1:0]   cfg_wdata
);
	import ctfp_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;            // centre minus point
	localparam int SQW = 2 * DW + 2;        // D, r^2, tol^2
	localparam int RTW = SQW / 2 + 1;       // root width
	localparam int NW  = DW + RTW + 4;      // numerator width

	logic [TOL_W-1:0] rel_tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_tol_q <= TOL_W'(1);
		end else if (cfg_we) begin
			rel_tol_q <= cfg_wdata;
		end
	end

	// Output register and global advance.
	logic en;
	result_t res_q;
	logic    res_v_q;
	assign en            = !res_v_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: differences and tolerance.
	logic signed [CW-1:0] cx, cy, px, py;
	logic [CW-2:0]        rr;
	assign cx = s_axis_tdata[CW-1:0];
	assign cy = s_axis_tdata[2*CW-1:CW];
	assign px = s_axis_tdata[3*CW-1:2*CW];
	assign py = s_axis_tdata[4*CW-1:3*CW];
	assign rr = s_axis_tdata[5*CW-2:4*CW];

	logic                  v_s1;
	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic signed [CW-1:0]  px_s1, py_s1;
	logic [CW-2:0]         r_s1, tol_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DW'(cx) - DW'(px);
			dy_s1  <= DW'(cy) - DW'(py);
			px_s1  <= px;
			py_s1  <= py;
			r_s1   <= rr;
			tol_s1 <= (CW-1)'((CW+TOL_W-1)'(rr) * (CW+TOL_W-1)'(rel_tol_q) >> TOL_W);
		end
	end

	// Stage 2: squares.
	logic             v_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic signed [CW-1:0] px_s2, py_s2;
	logic [CW-2:0]    r_s2;
	logic [SQW-1:0]   dxx_s2, dyy_s2, r2_s2, t2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			r_s2   <= r_s1;
			dxx_s2 <= SQW'($signed(SQW'(dx_s1)) * $signed(SQW'(dx_s1)));
			dyy_s2 <= SQW'($signed(SQW'(dy_s1)) * $signed(SQW'(dy_s1)));
			r2_s2  <= SQW'(r_s1) * SQW'(r_s1);
			t2_s2  <= SQW'(tol_s1) * SQW'(tol_s1);
		end
	end

	// Stage 3: distance and classification.
	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic [CW-2:0]        r;
		logic [SQW-1:0]       d;
		status_t              st;
	} geo_t;

	logic  v_s3;
	geo_t  g_s3;
	logic [SQW-1:0] root_s3;
	logic [SQW-1:0] dsum;
	assign dsum = dxx_s2 + dyy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			g_s3.dx <= dx_s2;
			g_s3.dy <= dy_s2;
			g_s3.px <= px_s2;
			g_s3.py <= py_s2;
			g_s3.r  <= r_s2;
			g_s3.d  <= dsum;
			root_s3 <= (dsum >= r2_s2) ? dsum - r2_s2 : '0;
			if (dsum == '0 || dsum < t2_s2)            g_s3.st <= ST_COINCIDE;
			else if ((dsum + t2_s2) < r2_s2)           g_s3.st <= ST_INSIDE;
			else if (dsum < (r2_s2 + t2_s2))           g_s3.st <= ST_ON_CIRCLE;
			else                                       g_s3.st <= ST_TWO;
		end
	end

	// Square root of D - r^2.
	logic             v_sq;
	logic [RTW-1:0]   s_sq;
	geo_t             g_sq;
	ctfp_isqrt #(.IN_W(SQW), .OUT_W(RTW), .PAY_W($bits(geo_t))) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (v_s3), .radicand (root_s3), .in_pay (g_s3),
		.out_valid(v_sq), .root (s_sq), .out_pay (g_sq)
	);

	// Stage 4: products.
	logic v_s4;
	geo_t g_s4;
	logic signed [NW-1:0] ax_s4, by_s4, rx_s4, ry_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_sq;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			g_s4  <= g_sq;
			ax_s4 <= $signed(NW'(g_sq.dx)) * $signed(NW'({1'b0, s_sq}));
			by_s4 <= $signed(NW'(g_sq.dy)) * $signed(NW'({1'b0, s_sq}));
			rx_s4 <= $signed(NW'(g_sq.dx)) * $signed(NW'({1'b0, g_sq.r}));
			ry_s4 <= $signed(NW'(g_sq.dy)) * $signed(NW'({1'b0, g_sq.r}));
		end
	end

	// Stage 5: numerators.
	logic v_s5;
	geo_t g_s5;
	logic signed [NW-1:0] n1x_s5, n1y_s5, n2x_s5, n2y_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			g_s5 <= g_s4;
			if (g_s4.st == ST_ON_CIRCLE) begin
				n1x_s5 <= -rx_s4;
				n1y_s5 <= -ry_s4;
				n2x_s5 <= -rx_s4;
				n2y_s5 <= -ry_s4;
			end else begin
				n1x_s5 <= -by_s4 - rx_s4;
				n1y_s5 <= ax_s4 - ry_s4;
				n2x_s5 <= -by_s4 + rx_s4;
				n2y_s5 <= ax_s4 + ry_s4;
			end
		end
	end

	// Four dividers in parallel, same latency.
	logic signed [31:0] q1x, q1y, q2x, q2y;
	logic               v_dv, v_u1, v_u2, v_u3;
	geo_t               g_dv, g_u1, g_u2, g_u3;
	logic [SQW-1:0]     den;
	assign den = (g_s5.d == '0) ? SQW'(1) : g_s5.d;
	ctfp_divq #(.NUM_W(NW), .D_W(SQW), .PAY_W($bits(geo_t))) u_div1x (
		.clk, .arst_n, .en, .in_valid(v_s5), .num(n1x_s5), .den, .in_pay(g_s5),
		.out_valid(v_dv), .quot(q1x), .out_pay(g_dv));
	ctfp_divq #(.NUM_W(NW), .D_W(SQW), .PAY_W($bits(geo_t))) u_div1y (
		.clk, .arst_n, .en, .in_valid(v_s5), .num(n1y_s5), .den, .in_pay(g_s5),
		.out_valid(v_u1), .quot(q1y), .out_pay(g_u1));
	ctfp_divq #(.NUM_W(NW), .D_W(SQW), .PAY_W($bits(geo_t))) u_div2x (
		.clk, .arst_n, .en, .in_valid(v_s5), .num(n2x_s5), .den, .in_pay(g_s5),
		.out_valid(v_u2), .quot(q2x), .out_pay(g_u2));
	ctfp_divq #(.NUM_W(NW), .D_W(SQW), .PAY_W($bits(geo_t))) u_div2y (
		.clk, .arst_n, .en, .in_valid(v_s5), .num(n2y_s5), .den, .in_pay(g_s5),
		.out_valid(v_u3), .quot(q2y), .out_pay(g_u3));

	// Stage 6: offset products.
	localparam int PW = 32 + CW + 2;
	logic v_s6;
	geo_t g_s6;
	logic signed [31:0] n1x_s6, n1y_s6, n2x_s6, n2y_s6;
	logic signed [PW-1:0] p1x_s6, p1y_s6, p2x_s6, p2y_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_dv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			g_s6   <= g_dv;
			n1x_s6 <= q1x; n1y_s6 <= q1y; n2x_s6 <= q2x; n2y_s6 <= q2y;
			p1x_s6 <= PW'(q1x) * PW'(g_dv.px);
			p1y_s6 <= PW'(q1y) * PW'(g_dv.py);
			p2x_s6 <= PW'(q2x) * PW'(g_dv.px);
			p2y_s6 <= PW'(q2y) * PW'(g_dv.py);
		end
	end

	// Round, shift and saturate an offset.
	function automatic logic signed [31:0] offs(input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b);
		logic signed [PW:0] s;
		logic signed [PW:0] t;
		s = -($signed({a[PW-1], a}) + $signed({b[PW-1], b})) + (PW+1)'(1 << 29);
		t = s >>> UNIT_SH;
		if (t > (PW+1)'(32'sh7FFFFFFF))       offs = 32'sh7FFFFFFF;
		else if (t < -(PW+1)'(64'sh80000000)) offs = 32'sh80000000;
		else                                  offs = t[31:0];
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (en) res_v_q <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.pad    <= '0;
			res_q.status <= g_s6.st;
			if (g_s6.st == ST_COINCIDE || g_s6.st == ST_INSIDE) begin
				res_q.normal1_x <= '0; res_q.normal1_y <= '0; res_q.offset1 <= '0;
				res_q.normal2_x <= '0; res_q.normal2_y <= '0; res_q.offset2 <= '0;
			end else begin
				res_q.normal1_x <= n1x_s6;
				res_q.normal1_y <= n1y_s6;
				res_q.offset1   <= offs(p1x_s6, p1y_s6);
				res_q.normal2_x <= n2x_s6;
				res_q.normal2_y <= n2y_s6;
				res_q.offset2   <= offs(p2x_s6, p2y_s6);
			end
		end
	end

	assign m_axis_tvalid = res_v_q;
	assign m_axis_tdata  = res_q;

	// The four dividers march in lockstep and carry the same payload.
	a_div_lock: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv == v_u1 && v_dv == v_u2 && v_dv == v_u3 &&
		(!v_dv || (g_dv == g_u1 && g_dv == g_u2 && g_dv == g_u3)))
		else $error("divider lanes out of step");
	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped during stall");
	// Failure cases report a zero normal1_x and a zero offset2.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_q.status == ST_COINCIDE || res_q.status == ST_INSIDE)
		|-> res_q.normal1_x == '0 && res_q.offset2 == '0)
		else $error("failure case with nonzero output");
endmodule

/* rtl/ctfp_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on ctfp_pkg; carries a side payload of generic width alongside.
module ctfp_isqrt #(
	parameter int IN_W  = 128,
	parameter int OUT_W = 64,
	parameter int PAY_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [PAY_W-1:0]  in_pay,
	output logic              out_valid,
	output logic [OUT_W-1:0]  root,
	output logic [PAY_W-1:0]  out_pay
);
	import ctfp_pkg::*;

	// Radicand is consumed two bits per stage; the remainder never exceeds twice the root.
	localparam int XW   = 2 * OUT_W;
	localparam int REMW = OUT_W + 3;

	logic [XW-1:0]    x_s   [OUT_W+1];
	logic [REMW-1:0]  rem_s [OUT_W+1];
	logic [OUT_W-1:0] r_s   [OUT_W+1];
	logic [PAY_W-1:0] p_s   [OUT_W+1];
	logic             v_s   [OUT_W+1];

	assign x_s[0]   = XW'(radicand);
	assign rem_s[0] = '0;
	assign r_s[0]   = '0;
	assign p_s[0]   = in_pay;
	assign v_s[0]   = in_valid;

	// Each stage tries one bit, most significant first.
	for (genvar g = 0; g < OUT_W; g++) begin : g_bit
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		assign rem_sh = {rem_s[g][REMW-3:0], x_s[g][XW-1:XW-2]};
		assign trial  = REMW'({r_s[g], 2'b01});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= x_s[g] << 2;
				p_s[g+1] <= p_s[g];
				if (rem_sh >= trial) begin
					rem_s[g+1] <= rem_sh - trial;
					r_s[g+1]   <= {r_s[g][OUT_W-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= rem_sh;
					r_s[g+1]   <= {r_s[g][OUT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[OUT_W];
	assign root      = r_s[OUT_W];
	assign out_pay   = p_s[OUT_W];
endmodule

/* rtl/ctfp_divq.sv */
// Pipelined restoring divider: floor(mag * 2^30 / d), capped to 2^30 with sign applied.
// Depends on ctfp_pkg; one quotient bit per stage.
module ctfp_divq #(
	parameter int NUM_W = 128,
	parameter int D_W   = 128,
	parameter int PAY_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [NUM_W-1:0] num,
	input  logic [D_W-1:0]          den,
	input  logic [PAY_W-1:0]        in_pay,
	output logic                    out_valid,
	output logic signed [31:0]      quot,
	output logic [PAY_W-1:0]        out_pay
);
	import ctfp_pkg::*;

	// Quotient bits: the result is capped at 2^30, which fits in 31 bits; 32 are kept, plus an overflow flag.
	localparam int QB = 32;
	localparam int EW = NUM_W + UNIT_SH;

	logic [EW-1:0]     r_s [QB+1];
	logic [D_W-1:0]    d_s [QB+1];
	logic [QB-1:0]     q_s [QB+1];
	logic              ng_s [QB+1];
	logic              big_s [QB+1];
	logic [PAY_W-1:0]  p_s [QB+1];
	logic              v_s [QB+1];
	logic [NUM_W-1:0]  mag;

	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	// The shifted dividend is the first partial remainder; a quotient of 2^QB or more
	// means saturation.
	assign r_s[0]   = EW'(mag) << UNIT_SH;
	assign d_s[0]   = den;
	assign q_s[0]   = '0;
	assign ng_s[0]  = num[NUM_W-1];
	assign big_s[0] = ((EW'(mag) << UNIT_SH) >> QB) >= EW'(den);
	assign p_s[0]   = in_pay;
	assign v_s[0]   = in_valid;

	for (genvar g = 0; g < QB; g++) begin : g_bit
		localparam int B = QB - 1 - g;
		logic [EW-1:0] dsh;
		assign dsh = EW'(d_s[g]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[g+1]   <= d_s[g];
				ng_s[g+1]  <= ng_s[g];
				big_s[g+1] <= big_s[g];
				p_s[g+1]   <= p_s[g];
				if (r_s[g] >= dsh) begin
					r_s[g+1] <= r_s[g] - dsh;
					q_s[g+1] <= q_s[g] | (QB'(1) << B);
				end else begin
					r_s[g+1] <= r_s[g];
					q_s[g+1] <= q_s[g];
				end
			end
		end
	end

	logic [QB-1:0] qc;
	assign qc = (big_s[QB] || q_s[QB] > (QB'(1) << UNIT_SH)) ? (QB'(1) << UNIT_SH) : q_s[QB];
	assign quot      = ng_s[QB] ? -$signed(qc) : $signed(qc);
	assign out_valid = v_s[QB];
	assign out_pay   = p_s[QB];
endmodule

/* tb/sv/tb_circle_tangents_checker.sv */
`timescale 1ns / 100ps
// Checker for the point-to-circle tangent pipeline: watches both stream channels and
// the tolerance write port, predicts each result word and compares it field by field.
// Depends on ctfp_pkg for the result layout and status codes.
module tb_circle_tangents_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [159:0]             s_axis_tdata,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [ctfp_pkg::ODATA_W-1:0] m_axis_tdata,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata,
	output int                       errors,
	output int                       pending
);
	import ctfp_pkg::*;

	localparam logic signed [127:0] UNIT_ONE = 128'sd1073741824;
	localparam logic signed [127:0] HALF_LSB = 128'sd536870912;
	localparam logic signed [127:0] OFS_MAX  = 128'sd2147483647;
	localparam logic signed [127:0] OFS_MIN  = -128'sd2147483648;

	result_t     tangent_words[$];
	logic [15:0] rel_tol;

	// Floor of the square root of a non-negative value, one bit at a time.
	function automatic logic signed [127:0] floor_sqrt(input logic signed [127:0] x);
		logic signed [127:0] root, cand;
		root = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'sd1 <<< b);
			if (cand * cand <= x)
				root = cand;
		end
		return root;
	endfunction

	// One component of a unit normal in Q2.30: num / d truncated toward zero, clamped.
	function automatic logic signed [31:0] unit_component(input logic signed [127:0] num,
			input logic signed [127:0] d);
		logic signed [127:0] mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< 30) / d;
		if (q > UNIT_ONE)
			q = UNIT_ONE;
		return (num < 0) ? -q[31:0] : q[31:0];
	endfunction

	// Line offset c = -(n . p), rounded half up from Q2.30 x Q16.16, saturated.
	function automatic logic signed [31:0] line_offset(input logic signed [31:0] nx,
			input logic signed [31:0] ny, input logic signed [127:0] px,
			input logic signed [127:0] py);
		logic signed [127:0] acc;
		acc = -(nx * px + ny * py) + HALF_LSB;
		acc = acc >>> 30;
		if (acc > OFS_MAX)
			return 32'sh7FFFFFFF;
		if (acc < OFS_MIN)
			return 32'sh80000000;
		return acc[31:0];
	endfunction

	function automatic result_t predict_tangents(input logic [159:0] w,
			input logic [15:0] tol_frac);
		logic signed [127:0] cx, cy, px, py, dx, dy, rs, tol, d, t2, r2, s;
		logic signed [127:0] n1x, n1y, n2x, n2y;
		result_t res;
		res = '0;
		cx = $signed(w[31:0]);
		cy = $signed(w[63:32]);
		px = $signed(w[95:64]);
		py = $signed(w[127:96]);
		rs = {97'd0, w[158:128]};
		dx = cx - px;
		dy = cy - py;
		tol = (rs * $signed({112'd0, tol_frac})) >>> 16;
		d = dx * dx + dy * dy;
		t2 = tol * tol;
		r2 = rs * rs;
		// Degenerate cases leave every normal and offset at zero.
		if (d == 0 || d < t2) begin
			res.status = ST_COINCIDE;
			return res;
		end
		if (d + t2 < r2) begin
			res.status = ST_INSIDE;
			return res;
		end
		if (d < r2 + t2) begin
			// Point on the circle: a single tangent, reported twice.
			n1x = -(rs * dx);
			n1y = -(rs * dy);
			n2x = n1x;
			n2y = n1y;
			res.status = ST_ON_CIRCLE;
		end else begin
			s = floor_sqrt(d - r2);
			n1x = -(dy * s) - rs * dx;
			n1y = dx * s - rs * dy;
			n2x = -(dy * s) + rs * dx;
			n2y = dx * s + rs * dy;
			res.status = ST_TWO;
		end
		res.normal1_x = unit_component(n1x, d);
		res.normal1_y = unit_component(n1y, d);
		res.normal2_x = unit_component(n2x, d);
		res.normal2_y = unit_component(n2y, d);
		res.offset1 = line_offset(res.normal1_x, res.normal1_y, px, py);
		res.offset2 = line_offset(res.normal2_x, res.normal2_y, px, py);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		errors++;
	endtask

	initial errors = 0;

	// Track the tolerance register, queue predictions and check each result word.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			rel_tol <= 16'd1;
		end else begin
			if (cfg_we)
				rel_tol <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				tangent_words.push_back(predict_tangents(s_axis_tdata, rel_tol));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (tangent_words.size() == 0) begin
					$display("%0t: result word with no prediction waiting", $realtime);
					errors++;
				end else begin
					want = tangent_words.pop_front();
					if (got.normal1_x !== want.normal1_x)
						report_mismatch("normal1_x", got.normal1_x, want.normal1_x);
					if (got.normal1_y !== want.normal1_y)
						report_mismatch("normal1_y", got.normal1_y, want.normal1_y);
					if (got.offset1 !== want.offset1)
						report_mismatch("offset1", got.offset1, want.offset1);
					if (got.normal2_x !== want.normal2_x)
						report_mismatch("normal2_x", got.normal2_x, want.normal2_x);
					if (got.normal2_y !== want.normal2_y)
						report_mismatch("normal2_y", got.normal2_y, want.normal2_y);
					if (got.offset2 !== want.offset2)
						report_mismatch("offset2", got.offset2, want.offset2);
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
				end
			end
			pending <= tangent_words.size();
		end
	end

	initial pending = 0;

endmodule

/* tb/sv/tb_circle_tangents_from_point.sv */
`timescale 1ns / 100ps
// Top of the tangent pipeline testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on ctfp_pkg, circle_tangents_from_point and tb_circle_tangents_checker.
module tb_circle_tangents_from_point;
	import ctfp_pkg::*;

	localparam int DRAIN_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 160;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	// centre_x, centre_y, point_x, point_y, radius, zero pad
	logic [159:0]            s_axis_tdata;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// normal1_x, normal1_y, offset1, normal2_x, normal2_y, offset2, status
	logic [ODATA_W-1:0]      m_axis_tdata;
	logic                    cfg_we;
	logic [TOL_W-1:0]        cfg_wdata;
	int                      errors;
	int                      pending;
	bit                      quiet;
	bit                      hold_req;

	circle_tangents_from_point #(.COORD_WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	tb_circle_tangents_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random gap length: mostly none, some short, a few long.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = 400;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					stall_left = gap_len();
			end
		end
	end

	task automatic send_word(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] px, input logic [31:0] py, input logic [30:0] r);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r, py, px, cy, cx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random pair, weighted toward well-formed geometry of each kind.
	task automatic send_random();
		logic signed [31:0] cx, cy, px, py, ox, oy;
		logic [30:0] r;
		int kind;
		kind = $urandom_range(0, 99);
		cx = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		cy = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		r = 31'($urandom_range(1, 1 << 22));
		ox = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		oy = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		if (kind < 20) begin
			send_word($urandom, $urandom, $urandom, $urandom, 31'($urandom));
		end else if (kind < 50) begin
			// Point shifted from the centre by a random offset plus the radius along x.
			send_word(cx, cy, cx + ox + r + 1, cy + oy, r);
		end else if (kind < 65) begin
			// Point on or just off the circle.
			if ($urandom_range(0, 1))
				send_word(cx, cy, cx + r, cy + $urandom_range(0, 3), r);
			else
				send_word(cx, cy, cx - $urandom_range(0, 3), cy - r, r);
		end else if (kind < 75) begin
			// Point at or next to the centre.
			send_word(cx, cy, cx + $urandom_range(0, 2), cy - $urandom_range(0, 2), r);
		end else if (kind < 85) begin
			// Point strictly inside.
			send_word(cx, cy, cx + (r >> 2), cy - (r >> 3), r);
		end else begin
			// Far point with a big radius, driving offsets toward saturation.
			px = $urandom_range(0, 1) ? 32'sh7FFF0000 + ox[15:0] : 32'sh80000000 + ox[15:0];
			py = $urandom;
			send_word(-px, ox, px, py, 31'($urandom_range(1 << 28, 32'h7FFFFFFF)));
		end
	endtask

	initial begin
		logic [15:0] tol_steps[6];
		tol_steps = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1};
		tol_steps[3] = 16'($urandom);
		tol_steps[4] = 16'($urandom_range(1, 4096));
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			write_tolerance(tol_steps[ph]);
			quiet = (ph == 3);
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == 0) begin
				// Extremes of every field and each classification.
				send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
				send_word(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'd0);
				send_word(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 31'd1);
				send_word(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF);
				send_word(0, 0, 0, 0, 0);
				send_word(0, 0, 0, 0, 31'h7FFFFFFF);
				send_word(0, 0, 32'h00010000, 0, 31'd0);
				send_word(0, 0, 32'h00020000, 0, 31'h00010000);
				send_word(0, 0, 32'h00010000, 0, 31'h00010000);
				send_word(0, 0, 0, 32'hFFFF0000, 31'h00010000);
				send_word(0, 0, 32'h00000100, 0, 31'h00010000);
				send_word(32'h00050000, 32'hFFFB0000, 32'h00050001, 32'hFFFB0000, 31'h7FFFFFFF);
				send_word(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h40000000);
				send_word(0, 0, 32'h80000000, 32'h00000001, 31'h7FFFFFFF);
				send_word(32'h00030000, 32'h00040000, 0, 0, 31'h00050000);
				send_word(32'h00030000, 32'h00040000, 0, 0, 31'h00020000);
				send_word(32'hFFFFFFFF, 0, 0, 0, 31'd0);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Overall time limit.
	initial begin
		#20ms;
		$display("%0t: timeout", $realtime);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
